// ===== sv/dtu_pkg.sv =====
// Package with the shared types, constants and codes of the dictionary text unpacker.
`timescale 1ns / 1ps
package dtu_pkg;

  // Dictionary geometry and the longest word that is emitted.
  localparam int DICT_BYTES = 4096;
  localparam int MAX_WORD   = 64;
  localparam int ADDR_W     = $clog2(DICT_BYTES);
  localparam int POS_W      = ADDR_W + 1;
  localparam int K_W        = $clog2(MAX_WORD + 1);
  localparam int N_W        = 7;

  // Packed byte codes.
  localparam logic [7:0] CODE_ESCAPE = 8'h80;
  localparam logic [7:0] CODE_IGNORE = 8'hFF;
  localparam logic [7:0] CODE_WORD0  = 8'h81;

  // Result status codes.
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_TRUNC = 2'd1;
  localparam logic [1:0] STATUS_END   = 2'd2;

  // Input mode codes.
  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_TEXT  = 1'b1;

  // Classification of one input transaction.
  typedef enum logic [2:0] {
    KIND_WRITE,
    KIND_ESC_LIT,
    KIND_EOT,
    KIND_LIT,
    KIND_ESC,
    KIND_IGNORE,
    KIND_WORD
  } kind_t;

  // Source of the output byte.
  typedef enum logic [1:0] {
    SEL_INPUT,
    SEL_ZERO,
    SEL_HOLD
  } out_sel_t;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SKIP,
    ST_WORD
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       start;
    logic       pos_inc;
    logic       n_dec;
    logic       k_inc;
    logic       hold_load;
    logic       mem_we;
    logic       esc_set;
    logic       esc_clr;
    logic       out_load;
    out_sel_t   out_sel;
    logic       out_last;
    logic       out_eot;
    logic [1:0] out_status;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    kind_t kind;
    logic  n_zero;
    logic  pos_end;
    logic  k_zero;
    logic  k_max;
    logic  rdata_zero;
    logic  slot_free;
  } sts_t;

endpackage

// ===== sv/dtu_if.sv =====
// Channel interfaces for packed input transactions and unpacked result transactions.
`timescale 1ns / 1ps
interface dtu_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [11:0] dict_addr;
  logic [7:0] dict_byte;
  logic [7:0] packed_byte;

  modport source (output valid, mode, dict_addr, dict_byte, packed_byte, input ready);
  modport sink (input valid, mode, dict_addr, dict_byte, packed_byte, output ready);
endinterface

interface dtu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;
  logic       end_of_text;
  logic [1:0] status;

  modport source (output valid, out_byte, last, end_of_text, status, input ready);
  modport sink (input valid, out_byte, last, end_of_text, status, output ready);
endinterface

// ===== sv/dtu_ctrl.sv =====
// Controller state machine that sequences input decode, dictionary walk and word output.
`timescale 1ns / 1ps
module dtu_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  dtu_pkg::sts_t sts,
  output dtu_pkg::cmd_t cmd
);

  dtu_pkg::state_t state;
  dtu_pkg::state_t state_next;
  logic [1:0]      fin_status;
  logic            fin;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dtu_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Final status of a word, from the byte at the current position.
  always_comb begin
    fin        = 1'b0;
    fin_status = dtu_pkg::STATUS_OK;
    if (sts.k_max) begin
      fin = 1'b1;
      if (sts.pos_end) begin
        fin_status = dtu_pkg::STATUS_END;
      end else if (!sts.rdata_zero) begin
        fin_status = dtu_pkg::STATUS_TRUNC;
      end
    end else if (sts.pos_end) begin
      fin        = 1'b1;
      fin_status = dtu_pkg::STATUS_END;
    end else if (sts.rdata_zero) begin
      fin = 1'b1;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.out_sel    = dtu_pkg::SEL_INPUT;
    cmd.out_status = dtu_pkg::STATUS_OK;
    in_ready   = 1'b0;
    case (state)
      dtu_pkg::ST_IDLE: begin
        in_ready = sts.slot_free;
        if (in_valid && sts.slot_free) begin
          case (sts.kind)
            dtu_pkg::KIND_WRITE: begin
              cmd.mem_we = 1'b1;
            end
            dtu_pkg::KIND_ESC_LIT: begin
              cmd.esc_clr  = 1'b1;
              cmd.out_load = 1'b1;
              cmd.out_last = 1'b1;
            end
            dtu_pkg::KIND_EOT: begin
              cmd.esc_clr  = 1'b1;
              cmd.out_load = 1'b1;
              cmd.out_sel  = dtu_pkg::SEL_ZERO;
              cmd.out_last = 1'b1;
              cmd.out_eot  = 1'b1;
            end
            dtu_pkg::KIND_LIT: begin
              cmd.out_load = 1'b1;
              cmd.out_last = 1'b1;
            end
            dtu_pkg::KIND_ESC: begin
              cmd.esc_set = 1'b1;
            end
            dtu_pkg::KIND_WORD: begin
              cmd.start  = 1'b1;
              state_next = dtu_pkg::ST_SKIP;
            end
            default: begin
            end
          endcase
        end
      end

      // Walk past the terminators that precede the selected word.
      dtu_pkg::ST_SKIP: begin
        if (sts.n_zero) begin
          state_next = dtu_pkg::ST_WORD;
        end else if (sts.pos_end) begin
          if (sts.slot_free) begin
            cmd.out_load   = 1'b1;
            cmd.out_sel    = dtu_pkg::SEL_ZERO;
            cmd.out_last   = 1'b1;
            cmd.out_status = dtu_pkg::STATUS_END;
            state_next     = dtu_pkg::ST_IDLE;
          end
        end else begin
          cmd.pos_inc = 1'b1;
          cmd.n_dec   = sts.rdata_zero;
        end
      end

      // Emit the word one byte behind the read, so the last byte carries its flags.
      dtu_pkg::ST_WORD: begin
        if (fin) begin
          if (sts.k_zero) begin
            if (fin_status == dtu_pkg::STATUS_OK) begin
              state_next = dtu_pkg::ST_IDLE;
            end else if (sts.slot_free) begin
              cmd.out_load   = 1'b1;
              cmd.out_sel    = dtu_pkg::SEL_ZERO;
              cmd.out_last   = 1'b1;
              cmd.out_status = fin_status;
              state_next     = dtu_pkg::ST_IDLE;
            end
          end else if (sts.slot_free) begin
            cmd.out_load   = 1'b1;
            cmd.out_sel    = dtu_pkg::SEL_HOLD;
            cmd.out_last   = 1'b1;
            cmd.out_status = fin_status;
            state_next     = dtu_pkg::ST_IDLE;
          end
        end else if (sts.k_zero || sts.slot_free) begin
          cmd.out_load  = !sts.k_zero;
          cmd.out_sel   = dtu_pkg::SEL_HOLD;
          cmd.hold_load = 1'b1;
          cmd.k_inc     = 1'b1;
          cmd.pos_inc   = 1'b1;
        end
      end

      default: begin
        state_next = dtu_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/dtu_dp.sv =====
// Datapath with the dictionary memory, walk counters, escape flag and output register.
`timescale 1ns / 1ps
module dtu_dp (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       mode,
  input  logic [dtu_pkg::ADDR_W-1:0] dict_addr,
  input  logic [7:0]                 dict_byte,
  input  logic [7:0]                 packed_byte,
  input  dtu_pkg::cmd_t              cmd,
  output dtu_pkg::sts_t              sts,
  dtu_out_if.source                  out_ch
);

  logic [7:0]                mem [dtu_pkg::DICT_BYTES];
  logic [7:0]                rdata;
  logic [dtu_pkg::POS_W-1:0] pos;
  logic [dtu_pkg::POS_W-1:0] pos_next;
  logic [dtu_pkg::N_W-1:0]   n;
  logic [dtu_pkg::K_W-1:0]   k;
  logic [7:0]                hold;
  logic                      escape;
  logic                      out_valid;
  logic [7:0]                word_diff;
  logic [7:0]                sel_byte;
  dtu_pkg::kind_t            kind;

  // Classify the incoming transaction.
  always_comb begin
    if (mode == dtu_pkg::MODE_WRITE) begin
      kind = dtu_pkg::KIND_WRITE;
    end else if (escape) begin
      kind = dtu_pkg::KIND_ESC_LIT;
    end else if (packed_byte == 8'd0) begin
      kind = dtu_pkg::KIND_EOT;
    end else if (packed_byte < dtu_pkg::CODE_ESCAPE) begin
      kind = dtu_pkg::KIND_LIT;
    end else if (packed_byte == dtu_pkg::CODE_ESCAPE) begin
      kind = dtu_pkg::KIND_ESC;
    end else if (packed_byte == dtu_pkg::CODE_IGNORE) begin
      kind = dtu_pkg::KIND_IGNORE;
    end else begin
      kind = dtu_pkg::KIND_WORD;
    end
  end

  assign sts.kind       = kind;
  assign word_diff      = packed_byte - dtu_pkg::CODE_WORD0;
  assign sts.n_zero     = (n == '0);
  assign sts.pos_end    = (pos == dtu_pkg::POS_W'(dtu_pkg::DICT_BYTES));
  assign sts.k_zero     = (k == '0);
  assign sts.k_max      = (k == dtu_pkg::K_W'(dtu_pkg::MAX_WORD));
  assign sts.rdata_zero = (rdata == 8'd0);
  assign sts.slot_free  = !out_valid || out_ch.ready;

  // Walk position; the memory is read at the next position so data lines up.
  always_comb begin
    if (cmd.start) begin
      pos_next = '0;
    end else if (cmd.pos_inc) begin
      pos_next = pos + dtu_pkg::POS_W'(1);
    end else begin
      pos_next = pos;
    end
  end

  // Dictionary memory with registered read.
  always_ff @(posedge clk) begin
    if (cmd.mem_we && ({1'b0, dict_addr} < dtu_pkg::POS_W'(dtu_pkg::DICT_BYTES))) begin
      mem[dict_addr] <= dict_byte;
    end
    rdata <= mem[pos_next[dtu_pkg::ADDR_W-1:0]];
  end

  // Walk counters and the held word byte.
  always_ff @(posedge clk) begin
    pos <= pos_next;
    if (cmd.start) begin
      n <= word_diff[dtu_pkg::N_W-1:0];
      k <= '0;
    end else begin
      if (cmd.n_dec) begin
        n <= n - dtu_pkg::N_W'(1);
      end
      if (cmd.k_inc) begin
        k <= k + dtu_pkg::K_W'(1);
      end
    end
    if (cmd.hold_load) begin
      hold <= rdata;
    end
  end

  // Escape flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      escape <= 1'b0;
    end else if (cmd.esc_set) begin
      escape <= 1'b1;
    end else if (cmd.esc_clr) begin
      escape <= 1'b0;
    end
  end

  // Output byte source.
  always_comb begin
    case (cmd.out_sel)
      dtu_pkg::SEL_INPUT: sel_byte = packed_byte;
      dtu_pkg::SEL_HOLD:  sel_byte = hold;
      default:            sel_byte = 8'd0;
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
    if (cmd.out_load) begin
      out_ch.out_byte    <= sel_byte;
      out_ch.last        <= cmd.out_last;
      out_ch.end_of_text <= cmd.out_eot;
      out_ch.status      <= cmd.out_status;
    end
  end

  assign out_ch.valid = out_valid;

endmodule

// ===== sv/dictionary_token_text_unpacker.sv =====
// Top level of the dictionary text unpacker: controller and datapath joined to the channels.
//
// Usage: in_ch carries one transaction per packed item. With mode 0 it writes
// dict_byte into the 4096-byte dictionary at dict_addr and yields no result.
// With mode 1 it feeds packed_byte, which yields zero or more transactions on
// out_ch; the final one of an item has last set.
// Literals, the escaped byte and the terminator are registered and appear on
// out_ch the cycle after acceptance. A word token walks the dictionary from
// address 0 at one byte per cycle, while out_ch does not stall, through the
// single memory read port; each word byte passes from the read register
// through the hold register to the output register.
// One item is worked on at a time: in_ch.ready is high only while the block
// is idle and its output register is empty or being emptied.
// When out_ch stalls, a word's byte walk holds its place, resuming with no loss.
// Reset (rst, synchronous) clears the escape flag, the controller and the
// output register; dictionary contents are kept undefined until written.
`timescale 1ns / 1ps
module dictionary_token_text_unpacker (
  input  logic      clk,
  input  logic      rst,
  dtu_in_if.sink    in_ch,
  dtu_out_if.source out_ch
);

  dtu_pkg::cmd_t cmd;
  dtu_pkg::sts_t sts;

  // Sequencer.
  dtu_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Storage, counters and output register.
  dtu_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .mode        (in_ch.mode),
    .dict_addr   (in_ch.dict_addr),
    .dict_byte   (in_ch.dict_byte),
    .packed_byte (in_ch.packed_byte),
    .cmd         (cmd),
    .sts         (sts),
    .out_ch      (out_ch)
  );

endmodule

// ===== dv/tb_dictionary_token_text_unpacker.sv =====
// Testbench for the dictionary text unpacker: directed and random packed text against a predictor.
`timescale 1ns / 1ps
module tb_dictionary_token_text_unpacker;

  // Run length and timing bounds.
  localparam int unsigned RANDOM_ITEMS   = 260;
  localparam int unsigned SETTLE_CYCLES  = dtu_pkg::DICT_BYTES + 100;
  localparam int unsigned WATCHDOG_LIMIT = 5 * (dtu_pkg::DICT_BYTES + 100);
  localparam int unsigned PRINT_LIMIT    = 50;
  // The long filler word ends with a terminator just one full word before the store end.
  localparam int unsigned FILLER_END     = dtu_pkg::DICT_BYTES - dtu_pkg::MAX_WORD - 1;

  // One expected unpacked byte with its flags.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       eot;
    logic [1:0] status;
  } text_byte_t;

  logic clk;
  logic rst;

  dtu_in_if  in_ch ();
  dtu_out_if out_ch ();

  dictionary_token_text_unpacker uut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Predictor state: dictionary image, escape flag and the bytes still owed by the block.
  logic [7:0]  dict_img [dtu_pkg::DICT_BYTES];
  logic        escape_armed = 1'b0;
  text_byte_t  expected_text [$];
  int unsigned region_words;
  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles = 0;
  bit          idling_on = 1'b1;
  int unsigned stall_left = 0;
  int unsigned calm_left = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Queue one expected byte.
  function automatic void expect_byte(logic [7:0] data, logic last, logic eot, logic [1:0] status);
    text_byte_t item;
    item = '{data: data, last: last, eot: eot, status: status};
    expected_text.push_back(item);
  endfunction

  // Walk the dictionary image to the selected word and queue its bytes.
  function automatic void predict_word(int unsigned n);
    int unsigned pos;
    int unsigned k;
    logic [1:0]  status;
    text_byte_t  tail;
    pos    = 0;
    k      = 0;
    status = dtu_pkg::STATUS_OK;
    while (n > 0) begin
      if (pos >= dtu_pkg::DICT_BYTES) begin
        expect_byte(8'h00, 1'b1, 1'b0, dtu_pkg::STATUS_END);
        return;
      end
      if (dict_img[pos] == 8'h00) n--;
      pos++;
    end
    while (k < dtu_pkg::MAX_WORD) begin
      if (pos >= dtu_pkg::DICT_BYTES) begin
        status = dtu_pkg::STATUS_END;
        break;
      end
      if (dict_img[pos] == 8'h00) break;
      expect_byte(dict_img[pos], 1'b0, 1'b0, dtu_pkg::STATUS_OK);
      k++;
      pos++;
    end
    // A full-length word is cut short unless its terminator follows right away.
    if (k == dtu_pkg::MAX_WORD && status == dtu_pkg::STATUS_OK) begin
      if (pos >= dtu_pkg::DICT_BYTES) status = dtu_pkg::STATUS_END;
      else if (dict_img[pos] != 8'h00) status = dtu_pkg::STATUS_TRUNC;
    end
    if (k == 0) begin
      if (status != dtu_pkg::STATUS_OK) expect_byte(8'h00, 1'b1, 1'b0, status);
      return;
    end
    tail = expected_text.pop_back();
    tail.last   = 1'b1;
    tail.status = status;
    expected_text.push_back(tail);
  endfunction

  // Decode one packed text byte into the expected results.
  function automatic void predict_text(logic [7:0] code);
    if (escape_armed) begin
      escape_armed = 1'b0;
      expect_byte(code, 1'b1, 1'b0, dtu_pkg::STATUS_OK);
    end else if (code == 8'h00) begin
      expect_byte(8'h00, 1'b1, 1'b1, dtu_pkg::STATUS_OK);
    end else if (code < dtu_pkg::CODE_ESCAPE) begin
      expect_byte(code, 1'b1, 1'b0, dtu_pkg::STATUS_OK);
    end else if (code == dtu_pkg::CODE_ESCAPE) begin
      escape_armed = 1'b1;
    end else if (code != dtu_pkg::CODE_IGNORE) begin
      predict_word(int'(code - dtu_pkg::CODE_WORD0));
    end
  endfunction

  // Present one input transaction, wait for acceptance, then update the predictor.
  task automatic feed_item(logic mode, logic [11:0] addr, logic [7:0] dbyte, logic [7:0] pbyte);
    @(negedge clk);
    if (idling_on && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.mode        <= mode;
    in_ch.dict_addr   <= addr;
    in_ch.dict_byte   <= dbyte;
    in_ch.packed_byte <= pbyte;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    if (mode == dtu_pkg::MODE_WRITE) dict_img[addr] = dbyte;
    else predict_text(pbyte);
  endtask

  task automatic write_dict(logic [11:0] addr, logic [7:0] dbyte);
    feed_item(dtu_pkg::MODE_WRITE, addr, dbyte, 8'($urandom_range(0, 255)));
  endtask

  task automatic feed_text(logic [7:0] code);
    feed_item(dtu_pkg::MODE_TEXT, 12'($urandom_range(0, 4095)), 8'($urandom_range(0, 255)),
              code);
  endtask

  // Drop valid and hold the sender until every owed byte has come out.
  task automatic wait_for_drain();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (expected_text.size() != 0) @(posedge clk);
  endtask

  // Feed one message of random tokens, usually closed by a terminator.
  task automatic feed_message(input int unsigned tokens, input bit terminate,
                              output int unsigned items);
    int unsigned pick;
    int unsigned idx;
    items = 0;
    repeat (tokens) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        feed_text(8'($urandom_range(1, 127)));
        items++;
      end else if (pick < 75) begin
        // Mostly words near the front; now and then one deep or past the end.
        idx = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 125) : $urandom_range(0, 20);
        feed_text(dtu_pkg::CODE_WORD0 + 8'(idx));
        items++;
      end else if (pick < 88) begin
        feed_text(dtu_pkg::CODE_ESCAPE);
        feed_text(8'($urandom_range(0, 255)));
        items += 2;
      end else if (pick < 94) begin
        feed_text(dtu_pkg::CODE_IGNORE);
      end else begin
        feed_text(8'($urandom_range(0, 255)));
        items++;
      end
    end
    if (terminate) begin
      feed_text(8'h00);
      items++;
    end
  endtask

  // Fill the whole store: short words, full and overlong words, a filler and a tail word.
  task automatic test_dictionary_fill();
    logic [7:0]  plan [dtu_pkg::DICT_BYTES];
    int unsigned lens [$];
    int unsigned a;
    lens = '{1, 3, 0, 5, dtu_pkg::MAX_WORD, dtu_pkg::MAX_WORD + 1, 7};
    repeat (24) lens.push_back($urandom_range(0, 8));
    a = 0;
    foreach (lens[i]) begin
      repeat (lens[i]) begin
        plan[a] = 8'($urandom_range(1, 255));
        a++;
      end
      plan[a] = 8'h00;
      a++;
    end
    region_words = lens.size();
    for (int j = a; j < dtu_pkg::DICT_BYTES; j++) begin
      plan[j] = (j == FILLER_END) ? 8'h00 : 8'($urandom_range(1, 255));
    end
    for (int j = 0; j < dtu_pkg::DICT_BYTES; j++) write_dict(12'(j), plan[j]);
  endtask

  // Literal extremes, the ignore code and the closing terminator.
  task automatic test_literals();
    feed_text(8'h01);
    feed_text(dtu_pkg::CODE_IGNORE);
    feed_text(8'h7F);
    feed_text(8'h00);
  endtask

  // Escaped zero, escaped escape, escaped ignore, and an escape across a dictionary write.
  task automatic test_escape();
    feed_text(dtu_pkg::CODE_ESCAPE);
    feed_text(8'h00);
    feed_text(dtu_pkg::CODE_ESCAPE);
    feed_text(dtu_pkg::CODE_ESCAPE);
    feed_text(dtu_pkg::CODE_ESCAPE);
    feed_text(dtu_pkg::CODE_IGNORE);
    feed_text(dtu_pkg::CODE_ESCAPE);
    write_dict(12'(dtu_pkg::DICT_BYTES - 1), dict_img[dtu_pkg::DICT_BYTES - 1]);
    feed_text(dtu_pkg::CODE_WORD0);
  endtask

  // Short, empty, full-length and overlong words, the tail word and a walk off the end.
  task automatic test_words();
    for (int i = 0; i < 7; i++) feed_text(dtu_pkg::CODE_WORD0 + 8'(i));
    feed_text(dtu_pkg::CODE_WORD0 + 8'(region_words));
    feed_text(dtu_pkg::CODE_WORD0 + 8'(region_words + 1));
    feed_text(dtu_pkg::CODE_IGNORE - 8'd1);
  endtask

  // Words that meet the store end with and without bytes, then a walk past all terminators.
  task automatic test_store_end();
    write_dict(12'(dtu_pkg::DICT_BYTES - 56), 8'h00);
    feed_text(dtu_pkg::CODE_WORD0 + 8'(region_words + 2));
    write_dict(12'(dtu_pkg::DICT_BYTES - 1), 8'h00);
    feed_text(dtu_pkg::CODE_WORD0 + 8'(region_words + 3));
    feed_text(dtu_pkg::CODE_WORD0 + 8'(region_words + 4));
    wait_for_drain();
  endtask

  // Mostly well-formed messages, mixed with dictionary rewrites and stray bytes.
  task automatic test_random_text();
    int unsigned fed;
    int unsigned items;
    int unsigned pick;
    fed = 0;
    while (fed < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
        write_dict(($urandom_range(0, 3) == 0) ? 12'($urandom_range(0, 4095))
                                               : 12'($urandom_range(0, 255)),
                   ($urandom_range(0, 4) == 0) ? 8'h00 : 8'($urandom_range(1, 255)));
        fed++;
      end else if (pick < 20) begin
        feed_text(8'($urandom_range(0, 255)));
        fed++;
      end else begin
        feed_message($urandom_range(1, 10), $urandom_range(0, 9) != 0, items);
        fed += items;
      end
    end
    wait_for_drain();
  endtask

  // Closing stretch with both sides running flat out.
  task automatic test_steady_stream();
    int unsigned items;
    idling_on = 1'b0;
    repeat (4) feed_message($urandom_range(3, 8), 1'b1, items);
  endtask

  // Output side stalls in bursts, with calm stretches between them.
  initial out_ch.ready = 1'b0;
  always @(negedge clk) begin
    if (!idling_on) begin
      out_ch.ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ch.ready <= 1'b0;
    end else if (calm_left > 0) begin
      calm_left--;
      out_ch.ready <= 1'b1;
    end else if ($urandom_range(0, 1) == 0) begin
      stall_left = $urandom_range(1, 13) - 1;
      out_ch.ready <= 1'b0;
    end else begin
      calm_left = $urandom_range(1, 40) - 1;
      out_ch.ready <= 1'b1;
    end
  end

  task automatic report_mismatch(string what, int got, int want);
    if (mismatch_count < PRINT_LIMIT) begin
      $display("%0t: %s: got %0h, expected %0h", $realtime, what, got, want);
    end
    mismatch_count++;
  endtask

  // Compare each result transaction with the oldest owed byte.
  always @(posedge clk) begin
    text_byte_t want;
    if (!rst && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (expected_text.size() == 0) begin
        report_mismatch("result with nothing owed, out_byte", out_ch.out_byte, 0);
      end else begin
        want = expected_text.pop_front();
        if (out_ch.out_byte !== want.data)
          report_mismatch("out_byte", out_ch.out_byte, want.data);
        if (out_ch.last !== want.last)
          report_mismatch("last", out_ch.last, want.last);
        if (out_ch.end_of_text !== want.eot)
          report_mismatch("end_of_text", out_ch.end_of_text, want.eot);
        if (out_ch.status !== want.status)
          report_mismatch("status", out_ch.status, want.status);
      end
    end
  end

  // End the run when neither channel has moved for too long.
  always @(posedge clk) begin
    if (rst || (in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
        (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // Reset, then the tests in turn, then the final verdict.
  initial begin
    rst               = 1'b1;
    in_ch.valid       = 1'b0;
    in_ch.mode        = dtu_pkg::MODE_WRITE;
    in_ch.dict_addr   = '0;
    in_ch.dict_byte   = '0;
    in_ch.packed_byte = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_dictionary_fill();
    test_literals();
    test_escape();
    test_words();
    test_store_end();
    test_random_text();
    test_steady_stream();

    wait_for_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
